/* design/gba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gba_pkg
// Shared types and constants for the growable bump allocator.
// ----------------------------------------------------------------------------
package gba_pkg;

    localparam int SUM_W    = 33;   // base address plus cursor
    localparam int CAP_W    = 29;
    localparam int ALIGN_W  = 13;
    localparam int SIZE_W   = 24;
    localparam int PADDR_W  = 4;

    localparam logic [CAP_W-1:0] INIT_CAP_RST = 29'd4096;
    localparam logic [7:0]       PERIOD_RST   = 8'd30;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_INIT   = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [SIZE_W-1:0]  alloc_size;
        logic [ALIGN_W-1:0] align_bytes;
    } gba_req_t;

    typedef struct packed {
        logic [CAP_W-1:0] offset;
        logic             grew;
        logic             shrank;
        logic             refused;
        logic [CAP_W-1:0] capacity_now;
    } gba_rsp_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic pad_en;
        logic sum_en;
        logic grow_en;
        logic commit_alloc;
        logic feval_en;
        logic commit_frame;
    } gba_cmd_t;

    typedef struct packed {
        logic req_frame;
        logic req_align_zero;
        logic div_done;
        logic out_free;
    } gba_stat_t;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DIV     = 8'b0000_0010,
        S_PAD     = 8'b0000_0100,
        S_SUM     = 8'b0000_1000,
        S_GROW    = 8'b0001_0000,
        S_COMMIT  = 8'b0010_0000,
        S_FEVAL   = 8'b0100_0000,
        S_FCOMMIT = 8'b1000_0000
    } gba_state_t;

endpackage
`default_nettype wire

/* design/growable_bump_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// growable_bump_allocator
// Bump allocator over one region with capacity growth and delayed shrink.
// ----------------------------------------------------------------------------
// One transaction is processed at a time, and the input stalls until the current
// one is done. An allocate with zero alignment steps through accept, pad, sum,
// grow check and commit, and its result is registered at the commit. With
// nonzero alignment a remainder step comes between accept and pad: the
// bit-serial remainder unit computes (base_address + cursor) mod align_bytes,
// and the pad step follows once it signals done. A frame reset steps through
// accept, evaluation and commit. A finished result sits in an output register,
// so the next transaction is accepted while it waits to be taken. The commit of
// that next transaction waits until the register is free. Configuration
// registers (base 0x0, initial capacity 0x4, shrink period 0x8) are to be
// written by the user only while the block is idle; the block itself does not
// enforce this. Writing the initial capacity also reloads the current capacity.
// ----------------------------------------------------------------------------
module growable_bump_allocator #(
    parameter int unsigned CAPACITY_LIMIT = 268435456
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire gba_pkg::gba_req_t           req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output gba_pkg::gba_rsp_t                rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    gba_pkg::gba_cmd_t  cmd;
    gba_pkg::gba_stat_t stat;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    gba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gba_dp #(
        .CAPACITY_LIMIT (CAPACITY_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_wr    (cfg_wr),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata)
    );

endmodule
`default_nettype wire

/* design/gba_rem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gba_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gba_rem (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [gba_pkg::SUM_W-1:0]   dividend,
    input  wire logic [gba_pkg::ALIGN_W-1:0] divisor,
    output logic                             done,
    output logic [gba_pkg::ALIGN_W-1:0]      rem
);

    localparam int CNT_W = $clog2(gba_pkg::SUM_W + 1);

    logic [gba_pkg::SUM_W-1:0]   dvd_reg, dvd_next;
    logic [gba_pkg::ALIGN_W:0]   rem_reg, rem_next;
    logic [gba_pkg::ALIGN_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [gba_pkg::ALIGN_W:0]   trial;

    always_comb
    begin
        trial     = {rem_reg[gba_pkg::ALIGN_W-1:0], dvd_reg[gba_pkg::SUM_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(gba_pkg::SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[gba_pkg::SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = trial - {1'b0, div_reg};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[gba_pkg::ALIGN_W-1:0];

endmodule
`default_nettype wire

/* design/gba_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gba_dp
// Allocator datapath: config registers, cursor, capacity, peak, shrink timer,
// padding arithmetic and the result register.
// ----------------------------------------------------------------------------
module gba_dp #(
    parameter int unsigned CAPACITY_LIMIT = 268435456
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gba_pkg::gba_cmd_t           cmd,
    output gba_pkg::gba_stat_t               stat,
    input  wire gba_pkg::gba_req_t           req,
    output gba_pkg::gba_rsp_t                rsp,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    input  wire logic                        cfg_wr,
    input  wire logic [gba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata
);

    localparam int CW = gba_pkg::CAP_W;
    localparam logic [CW-1:0] LIMIT = CW'(CAPACITY_LIMIT);

    logic [31:0]   base_reg;
    logic [CW-1:0] init_reg;
    logic [7:0]    period_reg;
    logic [CW-1:0] cursor_reg, cap_reg, peak_reg;
    logic          pending_reg;
    logic [7:0]    count_reg;

    gba_pkg::gba_req_t item_reg;
    logic [CW:0]       padded_reg;
    logic [CW+1:0]     end_reg, ns_reg;
    logic              over_reg, hit_reg;
    logic [CW:0]       target_reg;

    gba_pkg::gba_rsp_t rsp_reg;
    logic              rsp_valid_reg;

    logic [1:0]                  reg_idx;
    logic [CW-1:0]               init_clamped;
    logic [gba_pkg::ALIGN_W-1:0] rem, pad;
    logic                        div_done;
    logic [gba_pkg::SUM_W-1:0]   dividend;
    logic [CW:0]                 peak2;
    logic                        refuse;

    assign reg_idx  = paddr[3:2];
    assign dividend = {1'b0, base_reg} + gba_pkg::SUM_W'(cursor_reg);

    gba_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (req.align_bytes),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb
    begin
        if (pwdata[CW-1:0] == '0)
            init_clamped = CW'(1);
        else if (pwdata[CW-1:0] > LIMIT)
            init_clamped = LIMIT;
        else
            init_clamped = pwdata[CW-1:0];
    end

    always_comb
    begin
        unique case (reg_idx)
            gba_pkg::REG_BASE:   prdata = base_reg;
            gba_pkg::REG_INIT:   prdata = 32'(init_reg);
            gba_pkg::REG_PERIOD: prdata = 32'(period_reg);
            default:             prdata = '0;
        endcase
    end

    assign pad = (item_reg.align_bytes == '0 || rem == '0) ? '0
                 : item_reg.align_bytes - rem;
    assign peak2  = {peak_reg, 1'b0};
    assign refuse = over_reg && (ns_reg > (CW+2)'(LIMIT));

    assign stat.req_frame      = (req.mode == gba_pkg::MODE_FRAME);
    assign stat.req_align_zero = (req.align_bytes == '0);
    assign stat.div_done       = div_done;
    assign stat.out_free       = !rsp_valid_reg || !rsp_stall;

    // working registers of one transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= req;
        if (cmd.pad_en)
            padded_reg <= (CW+1)'(cursor_reg) + (CW+1)'(pad);
        if (cmd.sum_en)
            end_reg <= (CW+2)'(padded_reg) + (CW+2)'(item_reg.alloc_size);
        if (cmd.grow_en)
        begin
            over_reg <= end_reg > (CW+2)'(cap_reg);
            ns_reg   <= (end_reg > {1'b0, cap_reg, 1'b0}) ? end_reg
                        : {1'b0, cap_reg, 1'b0};
        end
        if (cmd.feval_en)
        begin
            hit_reg    <= (count_reg == period_reg);
            target_reg <= (peak2 < {1'b0, init_reg}) ? {1'b0, init_reg} : peak2;
        end
        if (cmd.commit_alloc)
        begin
            rsp_reg.offset  <= refuse ? '0 : padded_reg[CW-1:0];
            rsp_reg.grew    <= over_reg && !refuse;
            rsp_reg.shrank  <= 1'b0;
            rsp_reg.refused <= refuse;
            rsp_reg.capacity_now <= (over_reg && !refuse) ? ns_reg[CW-1:0] : cap_reg;
        end
        if (cmd.commit_frame)
        begin
            rsp_reg.offset  <= '0;
            rsp_reg.grew    <= 1'b0;
            rsp_reg.refused <= 1'b0;
            if (pending_reg && hit_reg && target_reg < {1'b0, cap_reg})
            begin
                rsp_reg.shrank       <= 1'b1;
                rsp_reg.capacity_now <= target_reg[CW-1:0];
            end
            else
            begin
                rsp_reg.shrank       <= 1'b0;
                rsp_reg.capacity_now <= cap_reg;
            end
        end
    end

    // allocator state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            init_reg      <= gba_pkg::INIT_CAP_RST;
            period_reg    <= gba_pkg::PERIOD_RST;
            cursor_reg    <= '0;
            cap_reg       <= gba_pkg::INIT_CAP_RST;
            peak_reg      <= '0;
            pending_reg   <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit_alloc || cmd.commit_frame)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;

            if (cmd.commit_alloc && !refuse)
            begin
                if (over_reg)
                begin
                    cap_reg     <= ns_reg[CW-1:0];
                    pending_reg <= 1'b1;
                    count_reg   <= '0;
                end
                cursor_reg <= end_reg[CW-1:0];
                if (end_reg > (CW+2)'(peak_reg))
                    peak_reg <= end_reg[CW-1:0];
            end

            if (cmd.commit_frame)
            begin
                cursor_reg <= '0;
                if (pending_reg)
                begin
                    if (hit_reg)
                    begin
                        if (target_reg < {1'b0, cap_reg})
                            cap_reg <= target_reg[CW-1:0];
                        pending_reg <= 1'b0;
                        count_reg   <= '0;
                        peak_reg    <= '0;
                    end
                    else
                        count_reg <= count_reg + 8'd1;
                end
            end

            if (cfg_wr)
            begin
                unique case (reg_idx)
                    gba_pkg::REG_BASE:   base_reg <= pwdata;
                    gba_pkg::REG_INIT:
                    begin
                        init_reg <= init_clamped;
                        cap_reg  <= init_clamped;
                    end
                    gba_pkg::REG_PERIOD: period_reg <= pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

/* design/gba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gba_ctrl
// Sequencer for one allocate or frame-reset transaction at a time.
// ----------------------------------------------------------------------------
module gba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire gba_pkg::gba_stat_t stat,
    output gba_pkg::gba_cmd_t       cmd
);

    gba_pkg::gba_state_t state_reg, state_next;
    logic                accept;

    assign req_stall = (state_reg != gba_pkg::S_IDLE);
    assign accept    = req_valid && (state_reg == gba_pkg::S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            gba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (stat.req_frame)
                        state_next = gba_pkg::S_FEVAL;
                    else if (stat.req_align_zero)
                        state_next = gba_pkg::S_PAD;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = gba_pkg::S_DIV;
                    end
                end
            end
            gba_pkg::S_DIV:
            begin
                if (stat.div_done)
                    state_next = gba_pkg::S_PAD;
            end
            gba_pkg::S_PAD:
            begin
                cmd.pad_en = 1'b1;
                state_next = gba_pkg::S_SUM;
            end
            gba_pkg::S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = gba_pkg::S_GROW;
            end
            gba_pkg::S_GROW:
            begin
                cmd.grow_en = 1'b1;
                state_next  = gba_pkg::S_COMMIT;
            end
            gba_pkg::S_COMMIT:
            begin
                // hold until the result register can take the transaction
                if (stat.out_free)
                begin
                    cmd.commit_alloc = 1'b1;
                    state_next       = gba_pkg::S_IDLE;
                end
            end
            gba_pkg::S_FEVAL:
            begin
                cmd.feval_en = 1'b1;
                state_next   = gba_pkg::S_FCOMMIT;
            end
            gba_pkg::S_FCOMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit_frame = 1'b1;
                    state_next       = gba_pkg::S_IDLE;
                end
            end
            default:
                state_next = gba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gba_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* sim/tb_growable_bump_allocator.sv */
// ----------------------------------------------------------------------------
// tb_growable_bump_allocator
// Self-checking bench for the growable bump allocator. A behavioral model of
// cursor, alignment padding, capacity growth, refusal and the frame-reset
// shrink timer predicts one response per request transaction; responses are
// checked in order. The sender runs in random bursts, the receiver stalls on
// its own pattern, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_growable_bump_allocator;

    localparam longint unsigned CAP_LIMIT    = 64'd268435456;
    localparam int              DRAIN_CYCLES = 50;
    localparam int              MAX_REPORTS  = 10;
    localparam int              PHASE_ITEMS  = 16;
    localparam logic [1:0]      REG_UNUSED   = 2'd3;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_stall;
    gba_pkg::gba_req_t           req;
    logic                        rsp_valid;
    logic                        rsp_stall;
    gba_pkg::gba_rsp_t           rsp;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [gba_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // allocator model state and register copies
    longint unsigned     cfg_base     = 0;
    longint unsigned     cfg_init_cap = 4096;
    logic [7:0]          cfg_period   = 8'd30;
    longint unsigned     m_cursor     = 0;
    longint unsigned     m_cap        = 4096;
    longint unsigned     m_peak       = 0;
    logic                m_shrink_armed = 1'b0;
    logic [7:0]          m_frame_cnt  = 8'd0;

    gba_pkg::gba_rsp_t   alloc_outcomes[$];
    int                  mismatches   = 0;
    int                  burst_left   = 0;
    int                  stall_mode   = 0;
    int                  stall_left   = 0;

    growable_bump_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic gba_pkg::gba_rsp_t predict_outcome(gba_pkg::gba_req_t r);
        gba_pkg::gba_rsp_t o;
        longint unsigned   rem;
        longint unsigned   pad;
        longint unsigned   end_pos;
        longint unsigned   grown;
        longint unsigned   target;
        o = '0;
        if (r.mode == gba_pkg::MODE_FRAME)
        begin
            if (m_shrink_armed)
            begin
                if (m_frame_cnt == cfg_period)
                begin
                    target = 2 * m_peak;
                    if (target < cfg_init_cap)
                        target = cfg_init_cap;
                    if (target < m_cap)
                    begin
                        m_cap    = target;
                        o.shrank = 1'b1;
                    end
                    m_shrink_armed = 1'b0;
                    m_frame_cnt    = 8'd0;
                    m_peak         = 0;
                end
                else
                    m_frame_cnt = m_frame_cnt + 8'd1;
            end
            m_cursor = 0;
        end
        else
        begin
            pad = 0;
            if (r.align_bytes != 0)
            begin
                rem = (cfg_base + m_cursor) % 64'(r.align_bytes);
                if (rem != 0)
                    pad = 64'(r.align_bytes) - rem;
            end
            end_pos = m_cursor + pad + 64'(r.alloc_size);
            if (end_pos > m_cap)
            begin
                grown = 2 * m_cap;
                if (grown < end_pos)
                    grown = end_pos;
                if (grown > CAP_LIMIT)
                    o.refused = 1'b1;
                else
                begin
                    m_cap          = grown;
                    o.grew         = 1'b1;
                    m_shrink_armed = 1'b1;
                    m_frame_cnt    = 8'd0;
                end
            end
            if (!o.refused)
            begin
                o.offset = gba_pkg::CAP_W'(m_cursor + pad);
                m_cursor = end_pos;
                if (m_cursor > m_peak)
                    m_peak = m_cursor;
            end
        end
        o.capacity_now = gba_pkg::CAP_W'(m_cap);
        return o;
    endfunction

    function automatic gba_pkg::gba_req_t make_item(logic mode,
                                                    logic [gba_pkg::SIZE_W-1:0] size,
                                                    logic [gba_pkg::ALIGN_W-1:0] align);
        gba_pkg::gba_req_t r;
        r.mode        = mode;
        r.alloc_size  = size;
        r.align_bytes = align;
        return r;
    endfunction

    function automatic gba_pkg::gba_req_t random_item();
        gba_pkg::gba_req_t r;
        r.mode = ($urandom_range(0, 99) < 15) ? gba_pkg::MODE_FRAME : gba_pkg::MODE_ALLOC;
        case ($urandom_range(0, 9))
            0:       r.alloc_size = gba_pkg::SIZE_W'($urandom);
            1:       r.alloc_size = '1;
            2:       r.alloc_size = '0;
            default: r.alloc_size = gba_pkg::SIZE_W'($urandom_range(1, 2048));
        endcase
        case ($urandom_range(0, 5))
            0:       r.align_bytes = '0;
            1, 2:    r.align_bytes = 13'd1 << $urandom_range(0, 12);
            3:       r.align_bytes = gba_pkg::ALIGN_W'($urandom_range(1, 8191));
            default: r.align_bytes = gba_pkg::ALIGN_W'($urandom_range(1, 16));
        endcase
        return r;
    endfunction

    // one request transaction, then the sender's burst/gap pacing
    task automatic send_item(input gba_pkg::gba_req_t item);
        int gap;
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        alloc_outcomes.push_back(predict_outcome(item));
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (alloc_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        longint unsigned clamped;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            gba_pkg::REG_BASE:   cfg_base = 64'(value);
            gba_pkg::REG_INIT:
            begin
                clamped = 64'(value[gba_pkg::CAP_W-1:0]);
                if (clamped < 1)
                    clamped = 1;
                if (clamped > CAP_LIMIT)
                    clamped = CAP_LIMIT;
                cfg_init_cap = clamped;
                m_cap        = clamped;
            end
            gba_pkg::REG_PERIOD: cfg_period = value[7:0];
            default:    ;
        endcase
    endtask

    task automatic test_directed_items();
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd0, 13'd0));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd5, 13'd0));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd1, 13'd4096));   // pads up, grows to 8192
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd3, 13'd1));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd7, 13'd3));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd1, 13'd8191));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd16, 13'd5));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd2, 13'd64));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'hAAAAAA, 13'h1555));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'hFFFFFF, 13'h1FFF));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd0, 13'h1FFF));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'h555555, 13'h0AAA));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'hFFFFFF, 13'd4096));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'h123456, 13'd17));
    endtask

    // base + cursor runs past 32 bits here
    task automatic test_base_offset();
        wait_drained();
        write_reg(gba_pkg::REG_BASE, 32'hFFFF_FFFF);
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd3, 13'd4096));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd9, 13'd3));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd1, 13'd8191));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd1, 13'd2));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
        wait_drained();
        write_reg(gba_pkg::REG_BASE, 32'h1234_5677);
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd10, 13'd8));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd10, 13'd1000));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
    endtask

    task automatic test_capacity_limit();
        wait_drained();
        write_reg(gba_pkg::REG_BASE, 32'h0);
        // ninth max-size block grows exactly to the limit, the 17th is refused
        write_reg(gba_pkg::REG_INIT, 32'h0800_0000);
        for (int i = 0; i < 17; i++)
            send_item(make_item(gba_pkg::MODE_ALLOC, 24'hFFFFFF, 13'd0));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
        wait_drained();
        write_reg(gba_pkg::REG_INIT, 32'hFFFF_FFFF);                   // clamps to the limit
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'hFFFFFF, 13'd4096));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
        wait_drained();
        write_reg(gba_pkg::REG_INIT, 32'h0);                           // clamps to one byte
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd1, 13'd0));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd2, 13'd0));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
        wait_drained();
        write_reg(gba_pkg::REG_INIT, 32'hE000_0010);                   // upper bits dropped
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd20, 13'd0));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'd0, 13'd0));
    endtask

    // peak is held across the growth, so the target rarely undercuts capacity;
    // the timer paths are walked anyway: period zero, short period, 8-bit wrap
    task automatic test_shrink_timer();
        wait_drained();
        write_reg(gba_pkg::REG_INIT, 32'd64);
        write_reg(gba_pkg::REG_PERIOD, 32'd0);
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd200, 13'd0));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'($urandom), 13'($urandom)));
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd300, 13'd0));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'($urandom), 13'($urandom)));
        send_item(make_item(gba_pkg::MODE_FRAME, 24'($urandom), 13'($urandom)));
        wait_drained();
        write_reg(gba_pkg::REG_PERIOD, 32'd2);
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd1000, 13'd0));
        for (int i = 0; i < 4; i++)
            send_item(make_item(gba_pkg::MODE_FRAME, 24'($urandom), 13'($urandom)));
        wait_drained();
        write_reg(gba_pkg::REG_PERIOD, 32'd255);
        send_item(make_item(gba_pkg::MODE_ALLOC, 24'd5000, 13'd0));
        for (int i = 0; i < 20; i++)
            send_item(make_item(gba_pkg::MODE_FRAME, 24'($urandom), 13'($urandom)));
        wait_drained();
        // count is above the new period and has to wrap before it matches
        write_reg(gba_pkg::REG_PERIOD, 32'd3);
        for (int i = 0; i < 242; i++)
            send_item(make_item(gba_pkg::MODE_FRAME, 24'($urandom), 13'($urandom)));
    endtask

    task automatic test_random_phases();
        logic [31:0] bases[5];
        logic [31:0] caps[5];
        logic [31:0] periods[5];
        bases   = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
        caps    = '{32'd4096, 32'd1, $urandom_range(1, 65536),
                    32'h0800_0000 + $urandom_range(0, 32'h07FF_FFFF), 32'h1000_0000};
        periods = '{32'd30, 32'd0, 32'd1, 32'd255, $urandom_range(0, 255)};
        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            write_reg(gba_pkg::REG_BASE, bases[p]);
            write_reg(gba_pkg::REG_INIT, caps[p]);
            write_reg(gba_pkg::REG_PERIOD, periods[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(random_item());
        end
    endtask

    // response checker and receiver stall pattern
    always @(posedge clk)
    begin
        gba_pkg::gba_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (alloc_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected response transaction %p", $time, rsp);
            end
            else
            begin
                want = alloc_outcomes.pop_front();
                if (rsp.offset !== want.offset || rsp.grew !== want.grew ||
                    rsp.shrank !== want.shrank || rsp.refused !== want.refused ||
                    rsp.capacity_now !== want.capacity_now)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: response mismatch: expected %p, got %p",
                                 $time, want, rsp);
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 1);
            2:       rsp_stall <= ((stall_left % 5) < 2);
            default: rsp_stall <= stall_left[5];
        endcase
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_items();
        test_base_offset();
        test_capacity_limit();
        test_shrink_timer();
        test_random_phases();
        wait_drained();
        if (mismatches == 0)
            $display("tb_growable_bump_allocator OK");
        else
            $display("tb_growable_bump_allocator NOT OK");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb_growable_bump_allocator NOT OK");
        $finish;
    end

endmodule
